/* rtl/core/cdl_name_escaper_unit_macros.svh */
// Assertion helpers used by the checker file of this block.
`ifndef CDL_NAME_ESCAPER_UNIT_MACROS_SVH
`define CDL_NAME_ESCAPER_UNIT_MACROS_SVH

// Same-cycle implication, sampled at the rising edge of clk.
`define CNESC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising edge of clk.
`define CNESC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cnesc_pkg.sv */
package cnesc_pkg;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_CTRL_LO   = 8'h01;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7f;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;

   // Up to four output bytes for one input word, plus the index of the last one.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            is_error;
   } plan_type;

   typedef struct packed {
      logic has_room;
      logic has_item;
   } queue_status_type;

   function automatic logic is_listed_punct(input logic [7:0] c);
      // Space, the shell-like punctuation, brackets and the backslash itself.
      return c inside {8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28,
                       8'h29, 8'h2a, 8'h2c, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
                       8'h3f, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c,
                       8'h7d, 8'h7e};
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = CHAR_DIGIT_0 + 8'(v);
      end else begin
         r = CHAR_LOWER_A + 8'(v - 4'd10);
      end
      return r;
   endfunction

endpackage

/* rtl/core/cnesc_channels.sv */
interface cnesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       first_of_name;

   modport source (output valid, output char_byte, output first_of_name, input ready);
   modport sink (input valid, input char_byte, input first_of_name, output ready);
endinterface

interface cnesc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       name_error;

   modport source (output valid, output out_byte, output last_of_run, output name_error,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input name_error,
                 output ready);
endinterface

/* rtl/core/cnesc_front.sv */
module cnesc_front import cnesc_pkg::*; (
   cnesc_req_if.sink        req_ch,
   input  queue_status_type status,
   output logic             push,
   output plan_type         push_plan
);

   logic [7:0] c;
   logic       first;
   logic       bad_first;
   logic       is_ctrl;
   logic       is_digit;

   assign c     = req_ch.char_byte;
   assign first = req_ch.first_of_name;

   assign req_ch.ready = status.has_room;
   assign push         = req_ch.valid && status.has_room;

   always_comb begin
      bad_first = first && (((c >= CHAR_CTRL_LO) && (c <= CHAR_SPACE)) || (c == CHAR_DEL));
      is_ctrl   = (c < CHAR_SPACE) || (c == CHAR_DEL);
      is_digit  = (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);

      push_plan = '0;
      if (bad_first) begin
         push_plan.bytes[0] = CHAR_NUL;
         push_plan.last_idx = 2'd0;
         push_plan.is_error = 1'b1;
      end else if (first && is_digit) begin
         push_plan.bytes[0] = CHAR_BACKSLASH;
         push_plan.bytes[1] = c;
         push_plan.last_idx = 2'd1;
      end else if (is_ctrl) begin
         // A zero byte lands here too and comes out as a hex escape.
         push_plan.bytes[0] = CHAR_BACKSLASH;
         push_plan.bytes[1] = CHAR_PERCENT;
         push_plan.bytes[2] = hex_digit(c[7:4]);
         push_plan.bytes[3] = hex_digit(c[3:0]);
         push_plan.last_idx = 2'd3;
      end else if (is_listed_punct(c)) begin
         push_plan.bytes[0] = CHAR_BACKSLASH;
         push_plan.bytes[1] = c;
         push_plan.last_idx = 2'd1;
      end else begin
         push_plan.bytes[0] = c;
         push_plan.last_idx = 2'd0;
      end
   end

endmodule

/* rtl/core/cnesc_queue.sv */
module cnesc_queue import cnesc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  plan_type         push_plan,
   input  logic             pop,
   output plan_type         head_plan,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   plan_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_plan;
      end
   end

   assign head_plan       = entries_ff[rd_ptr_ff];
   assign status.has_room = (count_ff != CNT_FULL);
   assign status.has_item = (count_ff != '0);

endmodule

/* rtl/core/cnesc_back.sv */
module cnesc_back import cnesc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  plan_type         head_plan,
   input  queue_status_type status,
   output logic             pop,
   cnesc_rsp_if.source      rsp_ch
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load;
   logic       take;

   always_comb begin
      // The output register reloads whenever it is empty or its word is taken.
      load     = !valid_ff || rsp_ch.ready;
      take     = load && status.has_item;
      pop      = take && (idx_ff == head_plan.last_idx);
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = status.has_item;
      end
      if (take) begin
         byte_in = head_plan.bytes[idx_ff];
         last_in = (idx_ff == head_plan.last_idx);
         err_in  = head_plan.is_error;
         idx_in  = pop ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.name_error  = err_ff;

endmodule

/* rtl/core/cdl_name_escaper_unit.sv */
// Channel   Direction  Members
// req_ch    in         valid, ready, char_byte[7:0], first_of_name
// rsp_ch    out        valid, ready, out_byte[7:0], last_of_run, name_error
//
// One input word expands to one to four result words; the back end sends one
// result word per cycle while the receiver is ready and an item is queued.
// An accepted word is queued; its first result word is then loaded from there.
// Synchronous reset empties the queue and clears the output valid.
// A queue of QUEUE_DEPTH classified items keeps input accepted while the
// output is stalled; ready drops only when that queue is full.
module cdl_name_escaper_unit import cnesc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   cnesc_req_if.sink     req_ch,
   cnesc_rsp_if.source   rsp_ch
);

   queue_status_type status;
   logic             push;
   logic             pop;
   plan_type         push_plan;
   plan_type         head_plan;

   cnesc_front u_front (
      .req_ch    (req_ch),
      .status    (status),
      .push      (push),
      .push_plan (push_plan)
   );

   cnesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .pop       (pop),
      .head_plan (head_plan),
      .status    (status)
   );

   cnesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_plan (head_plan),
      .status    (status),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* rtl/core/cnesc_checker.sv */
`include "cdl_name_escaper_unit_macros.svh"

module cnesc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last_of_run,
   input logic       name_error
);

   `CNESC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({out_byte, last_of_run, name_error}), "stalled result word changed")
   `CNESC_ASSERT_IMPL(a_error_shape, clock, reset, rsp_valid && name_error, last_of_run && (out_byte == 8'h00), "error word is not a lone zero word")
   `CNESC_ASSERT_IMPL(a_no_zero_byte, clock, reset, rsp_valid && !name_error, out_byte != 8'h00, "zero byte in a normal result word")
   `CNESC_ASSERT_IMPL(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind cdl_name_escaper_unit cnesc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_byte    (rsp_ch.out_byte),
   .last_of_run (rsp_ch.last_of_run),
   .name_error  (rsp_ch.name_error)
);

/* tb/tb_cdl_name_escaper_unit.sv */
module tb_cdl_name_escaper_unit;
   import cnesc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 80;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       name_error;
   } esc_word_type;

   // Predicts the escaped words for every accepted name byte and checks the
   // words leaving the block against them in order.
   class escaped_word_book;
      esc_word_type escaped_q[$];
      int           failures;

      function new();
         failures = 0;
      endfunction

      function int pending();
         return escaped_q.size();
      endfunction

      function logic needs_backslash(logic [7:0] c);
         case (c)
            8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2a, 8'h2c, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h5b,
            8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d, 8'h7e: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function logic [7:0] nibble_char(logic [3:0] v);
         if (v < 4'd10) begin
            return CHAR_DIGIT_0 + 8'(v);
         end
         return CHAR_LOWER_A + 8'(v - 4'd10);
      endfunction

      function void note_char(logic [7:0] c, logic first);
         logic [7:0]   outs [4];
         int           n;
         esc_word_type w;
         n = 0;
         if (first && ((c >= CHAR_CTRL_LO && c <= CHAR_SPACE) || c == CHAR_DEL)) begin
            w.out_byte = 8'h00;
            w.last_of_run = 1'b1;
            w.name_error = 1'b1;
            escaped_q.push_back(w);
            return;
         end
         if (first && c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            outs[n] = CHAR_BACKSLASH;
            n = n + 1;
         end
         if (c < CHAR_SPACE || c == CHAR_DEL) begin
            outs[n] = CHAR_BACKSLASH;
            outs[n + 1] = CHAR_PERCENT;
            outs[n + 2] = nibble_char(c[7:4]);
            outs[n + 3] = nibble_char(c[3:0]);
            n = n + 4;
         end else if (needs_backslash(c)) begin
            outs[n] = CHAR_BACKSLASH;
            outs[n + 1] = c;
            n = n + 2;
         end else begin
            outs[n] = c;
            n = n + 1;
         end
         for (int i = 0; i < n; i++) begin
            w.out_byte = outs[i];
            w.last_of_run = (i == n - 1);
            w.name_error = 1'b0;
            escaped_q.push_back(w);
         end
      endfunction

      function void check_word(logic [7:0] b, logic last, logic err);
         esc_word_type want;
         if (escaped_q.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected word: byte %02h last %0b error %0b", b, last, err);
            end
            return;
         end
         want = escaped_q.pop_front();
         if (want.out_byte !== b || want.last_of_run !== last || want.name_error !== err) begin
            failures++;
            if (failures <= 10) begin
               $display("word mismatch: expected byte %02h last %0b error %0b, got byte %02h last %0b error %0b",
                        want.out_byte, want.last_of_run, want.name_error, b, last, err);
            end
         end
      endfunction

      function void close_out();
         if (escaped_q.size() != 0) begin
            failures += escaped_q.size();
            $display("%0d escaped words never arrived", escaped_q.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   cnesc_req_if req_ch();
   cnesc_rsp_if rsp_ch();

   cdl_name_escaper_unit dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   escaped_word_book book = new();
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_left;
   bit hold_request;
   int cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("cdl_name_escaper_unit verification failed");
         $finish;
      end
   end

   // The receiver's ready, with one long hold-off in the last phase to fill the block.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         book.check_word(rsp_ch.out_byte, rsp_ch.last_of_run, rsp_ch.name_error);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_char(input logic [7:0] c, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.char_byte = c;
      req_ch.first_of_name = first;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      book.note_char(c, first);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_name_byte();
      case ($urandom_range(5))
         0: return ($urandom_range(7) == 0) ? CHAR_DEL : 8'($urandom_range(8'h1f));
         1: return 8'($urandom_range(8'h21, 8'h7e));
         2: return 8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9));
         3: return 8'($urandom_range(8'h61, 8'h7a));
         4: return 8'($urandom_range(8'h80, 8'hff));
         default: return CHAR_SPACE;
      endcase
   endfunction

   task automatic send_directed();
      // Bad first bytes, leading digits and first bytes that escape normally.
      send_char(8'h61, 1'b1);
      send_char(CHAR_CTRL_LO, 1'b1);
      send_char(CHAR_SPACE, 1'b1);
      send_char(CHAR_DEL, 1'b1);
      send_char(CHAR_NUL, 1'b1);
      send_char(CHAR_DIGIT_0, 1'b1);
      send_char(CHAR_DIGIT_9, 1'b1);
      send_char(8'h21, 1'b1);
      send_char(8'hff, 1'b1);
      send_char(8'h80, 1'b1);
      send_char(8'h7e, 1'b1);
      // The same classes of byte later in a name.
      send_char(CHAR_NUL, 1'b0);
      send_char(CHAR_CTRL_LO, 1'b0);
      send_char(8'h1f, 1'b0);
      send_char(CHAR_DEL, 1'b0);
      send_char(CHAR_SPACE, 1'b0);
      send_char(CHAR_BACKSLASH, 1'b0);
      send_char(8'h7e, 1'b0);
      send_char(8'h21, 1'b0);
      send_char(8'h35, 1'b0);
      send_char(8'h5a, 1'b0);
      send_char(8'hff, 1'b0);
      send_char(8'h2f, 1'b0);
      send_char(8'h3a, 1'b0);
   endtask

   // Mostly whole names of random bytes, with some loose random words between.
   task automatic send_random(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 15) begin
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_char(pick_name_byte(), i == 0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_byte = 8'h00;
      req_ch.first_of_name = 1'b0;
      rsp_ch.ready = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_left = 0;
      hold_request = 1'b0;
      cycles = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      tx_idle_pct = 32;
      rx_idle_pct = 83;
      send_directed();
      send_random(150);

      tx_idle_pct = 83;
      rx_idle_pct = 32;
      send_random(150);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request = 1'b1;
      send_random(140);
      req_ch.valid = 1'b0;

      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      book.close_out();
      if (book.failures == 0) begin
         $display("cdl_name_escaper_unit verification clean");
      end else begin
         $display("cdl_name_escaper_unit verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cnesc_pkg.sv
rtl/core/cnesc_channels.sv
rtl/core/cnesc_front.sv
rtl/core/cnesc_queue.sv
rtl/core/cnesc_back.sv
rtl/core/cdl_name_escaper_unit.sv
rtl/core/cnesc_checker.sv
tb/tb_cdl_name_escaper_unit.sv
